/* design/givm_pkg.sv */
// Shared constants, command codes and inter-cell structs for the interval matcher.
package givm_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 64;
  localparam int unsigned MAX_EXONS_DEF     = 16;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CHROM_W = 8;
  localparam int unsigned POS_W   = 31;
  localparam int unsigned RNG_W   = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned VAR_W   = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_INT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_EXON = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd3;

  localparam logic [MODE_W-1:0] MODE_TX     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EXON   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CODING = 2'd2;

  // Query token walking down the cell chain; carries the hit still waiting to go out.
  typedef struct packed {
    logic               valid;
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   pos;
    logic [MODE_W-1:0]  mode;
    logic               pend_v;
    logic [IDX_W-1:0]   pend_idx;
  } tok_t;

  // Result beat request from a cell or the controller.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             last;
  } emit_t;

  // Load broadcast to all cells.
  typedef struct packed {
    logic               add_int;
    logic               add_exon;
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   a;
    logic [POS_W-1:0]   b;
    logic [POS_W-1:0]   cs;
    logic [POS_W-1:0]   ce;
  } load_t;

endpackage

/* design/givm_cell.sv */
// One interval slot: stored ranges and exons, checks a passing query token.
module givm_cell #(
  parameter int unsigned MaxExons = givm_pkg::MAX_EXONS_DEF,
  parameter int unsigned CellIdx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  givm_pkg::load_t load_i,
  input  logic            sel_int_i,
  input  logic            sel_exon_i,
  input  givm_pkg::tok_t  tok_i,
  input  logic            tail_i,
  input  logic            out_free_i,
  output givm_pkg::tok_t  tok_o,
  output givm_pkg::emit_t emit_o,
  output logic            busy_o
);
  import givm_pkg::*;

  localparam int unsigned ExW = $clog2(MaxExons + 1);
  localparam int unsigned EiW = (MaxExons > 1) ? $clog2(MaxExons) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  tok_t               tok_q, tok_d;
  logic [EiW-1:0]     ex_q, ex_d;
  logic               res_hit_q, res_hit_d;

  logic [CHROM_W-1:0] chrom_q;
  logic [RNG_W-1:0]   tx_lo_q, tx_hi_q, cd_lo_q, cd_hi_q;
  logic [ExW-1:0]     ecnt_q;
  logic [RNG_W-1:0]   ex_start_q [MaxExons];
  logic [POS_W-1:0]   ex_size_q  [MaxExons];

  logic               coding, need_ex, rng_ok, ex_hit, ex_last;
  logic [RNG_W-1:0]   lo, hi, pos32;
  logic [RNG_W:0]     ex_end;

  // slot payload
  always_ff @(posedge clk_i) begin
    if (load_i.add_int && sel_int_i) begin
      chrom_q <= load_i.chrom;
      tx_lo_q <= {1'b0, load_i.a} + 32'd1;
      tx_hi_q <= {1'b0, load_i.b} + 32'd1;
      cd_lo_q <= {1'b0, load_i.cs} + 32'd1;
      cd_hi_q <= {1'b0, load_i.ce} + 32'd1;
      ecnt_q  <= '0;
    end else if (load_i.add_exon && sel_exon_i && (ecnt_q < ExW'(MaxExons))) begin
      ex_start_q[ecnt_q[EiW-1:0]] <= tx_lo_q + {1'b0, load_i.a};
      ex_size_q[ecnt_q[EiW-1:0]]  <= load_i.b;
      ecnt_q <= ecnt_q + ExW'(1);
    end
  end

  always_comb begin
    coding  = (tok_q.mode == MODE_CODING);
    need_ex = (tok_q.mode == MODE_EXON) || coding;
    lo      = coding ? cd_lo_q : tx_lo_q;
    hi      = coding ? cd_hi_q : tx_hi_q;
    pos32   = {1'b0, tok_q.pos};
    rng_ok  = (chrom_q == tok_q.chrom) && !(coding && (cd_hi_q <= cd_lo_q)) &&
              (pos32 >= lo) && (pos32 <= hi);
    ex_end  = {1'b0, ex_start_q[ex_q]} + {2'b0, ex_size_q[ex_q]};
    ex_hit  = (pos32 >= ex_start_q[ex_q]) && ({1'b0, pos32} <= ex_end);
    ex_last = ((ExW'(ex_q) + ExW'(1)) == ecnt_q);
  end

  always_comb begin
    state_d   = state_q;
    tok_d     = tok_q;
    ex_d      = ex_q;
    res_hit_d = res_hit_q;
    tok_o     = tok_q;
    tok_o.valid = 1'b0;
    emit_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (tok_i.valid) begin
          tok_d   = tok_i;
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        ex_d = '0;
        if (!rng_ok) begin
          res_hit_d = 1'b0;
          state_d   = ST_DONE;
        end else if (!need_ex) begin
          res_hit_d = 1'b1;
          state_d   = ST_DONE;
        end else if (ecnt_q == '0) begin
          res_hit_d = 1'b0;
          state_d   = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ex_hit) begin
          res_hit_d = 1'b1;
          state_d   = ST_DONE;
        end else if (ex_last) begin
          res_hit_d = 1'b0;
          state_d   = ST_DONE;
        end else begin
          ex_d = ex_q + EiW'(1);
        end
      end
      ST_DONE: begin
        if (res_hit_q && tok_q.pend_v) begin
          // older hit goes out now, this one becomes pending
          emit_o = '{valid: 1'b1, hit: 1'b1, idx: tok_q.pend_idx, last: 1'b0};
          if (out_free_i) begin
            tok_d.pend_idx = IDX_W'(CellIdx);
            res_hit_d      = 1'b0;
          end
        end else if (res_hit_q) begin
          tok_d.pend_v   = 1'b1;
          tok_d.pend_idx = IDX_W'(CellIdx);
          res_hit_d      = 1'b0;
        end else if (tail_i) begin
          emit_o = '{valid: 1'b1, hit: tok_q.pend_v,
                     idx: (tok_q.pend_v ? tok_q.pend_idx : '0), last: 1'b1};
          if (out_free_i) state_d = ST_IDLE;
        end else begin
          tok_o.valid = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q     <= tok_d;
    ex_q      <= ex_d;
    res_hit_q <= res_hit_d;
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* design/genomic_interval_variant_matcher.sv */
// Top level of the genomic interval matcher: command decode, cell chain, result register.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) takes one command beat: clear, add interval,
//   add exon to the last interval, or query. Loads and clear never raise in_stall_o.
//   A query is walked down a chain of interval cells, one slot at a time, in slot order.
//   The controller registers the token; each slot then runs a range check and a hand-off,
//   plus an exon scan step for each exon looked at in exon modes and an extra hand-off
//   step for each hit. An empty table sets a no-hit flag on the accept, and that flag
//   then puts the no-hit beat in the output register. The hand-off between neighboring
//   cells and the per-cell exon scan set the worst case per query.
//   While a query is in flight in_stall_o is high; the next beat is taken once the last
//   result beat of the query has entered the output register.
//   Output channel (out_valid_o / out_stall_i) gives one beat per hit, last_o on the final
//   one, or a single no-hit beat. A stall holds the output register and the cell holding
//   the token waits; nothing is dropped.
//   Config channel (cfg_valid_i / cfg_ready_o) writes match_mode; always ready.
//   Reset clears the interval count, query counter, mode and all control state; stored
//   interval and exon data stay undefined until loaded.
module genomic_interval_variant_matcher #(
  parameter int unsigned MaxIntervals = givm_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned MaxExons     = givm_pkg::MAX_EXONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [givm_pkg::MODE_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [givm_pkg::CMD_W-1:0]    cmd_i,
  input  logic [givm_pkg::CHROM_W-1:0]  chrom_id_i,
  input  logic [givm_pkg::POS_W-1:0]    pos_a_i,
  input  logic [givm_pkg::POS_W-1:0]    pos_b_i,
  input  logic [givm_pkg::POS_W-1:0]    coding_start_i,
  input  logic [givm_pkg::POS_W-1:0]    coding_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [givm_pkg::IDX_W-1:0]    interval_index_o,
  output logic [givm_pkg::VAR_W-1:0]    variant_index_o,
  output logic                          last_o
);
  import givm_pkg::*;

  localparam int unsigned CntW = $clog2(MaxIntervals + 1);

  logic [MODE_W-1:0] mode_q;
  logic [CntW-1:0]   count_q;
  logic [VAR_W-1:0]  qcnt_q;
  logic              busy_q, noh_q;
  tok_t              inj_q;

  logic              out_valid_q, hit_q, last_q;
  logic [IDX_W-1:0]  idx_q;
  logic [VAR_W-1:0]  var_q;

  logic              accept, out_free, fire;
  load_t             load;
  emit_t             emit_or, emit_sel;
  tok_t              tok_w  [MaxIntervals+1];
  emit_t             emit_w [MaxIntervals];
  logic [MaxIntervals-1:0] cell_busy;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    load.add_int  = accept && (cmd_i == CMD_ADD_INT) && (count_q < CntW'(MaxIntervals));
    load.add_exon = accept && (cmd_i == CMD_ADD_EXON);
    load.chrom    = chrom_id_i;
    load.a        = pos_a_i;
    load.b        = pos_b_i;
    load.cs       = coding_start_i;
    load.ce       = coding_end_i;
  end

  assign tok_w[0] = inj_q;

  for (genvar i = 0; i < MaxIntervals; i++) begin : g_cell
    givm_cell #(
      .MaxExons (MaxExons),
      .CellIdx  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (load),
      .sel_int_i  (count_q == CntW'(i)),
      .sel_exon_i (count_q == CntW'(i + 1)),
      .tok_i      (tok_w[i]),
      .tail_i     (count_q == CntW'(i + 1)),
      .out_free_i (out_free),
      .tok_o      (tok_w[i+1]),
      .emit_o     (emit_w[i]),
      .busy_o     (cell_busy[i])
    );
  end

  // only the token holder drives a request, so a plain OR merges them
  always_comb begin
    emit_or = '0;
    for (int i = 0; i < MaxIntervals; i++) begin
      emit_or = emit_or | emit_w[i];
    end
    emit_sel = noh_q ? emit_t'{valid: 1'b1, hit: 1'b0, idx: '0, last: 1'b1} : emit_or;
  end

  assign fire = emit_sel.valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TX;
      count_q     <= '0;
      qcnt_q      <= '0;
      busy_q      <= 1'b0;
      noh_q       <= 1'b0;
      inj_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      inj_q.valid <= 1'b0;
      if (accept) begin
        unique case (cmd_i)
          CMD_CLEAR: begin
            count_q <= '0;
            qcnt_q  <= '0;
          end
          CMD_ADD_INT: begin
            if (count_q < CntW'(MaxIntervals)) count_q <= count_q + CntW'(1);
          end
          CMD_ADD_EXON: ;
          CMD_QUERY: begin
            busy_q <= 1'b1;
            if (count_q == '0) begin
              noh_q <= 1'b1;
            end else begin
              inj_q.valid    <= 1'b1;
              inj_q.chrom    <= chrom_id_i;
              inj_q.pos      <= pos_a_i;
              inj_q.mode     <= (mode_q > MODE_CODING) ? MODE_TX : mode_q;
              inj_q.pend_v   <= 1'b0;
              inj_q.pend_idx <= '0;
            end
          end
          default: ;
        endcase
      end
      if (out_free) out_valid_q <= emit_sel.valid;
      if (fire && emit_sel.last) begin
        busy_q <= 1'b0;
        noh_q  <= 1'b0;
        qcnt_q <= qcnt_q + VAR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q  <= emit_sel.hit;
      idx_q  <= emit_sel.idx;
      last_q <= emit_sel.last;
      var_q  <= qcnt_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign interval_index_o = idx_q;
  assign variant_index_o  = var_q;
  assign last_o           = last_q;

  // the token sits in at most one cell
  a_one_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_busy))
    else $error("more than one cell holds the query token");

  // no cell works while the controller is idle
  a_idle_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cell_busy == '0))
    else $error("cell busy outside a query");

  // no result request without a query in flight
  a_no_stray_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !emit_sel.valid)
    else $error("result request while idle");

endmodule

/* sim/genomic_interval_variant_matcher_tb.sv */
// Self-checking testbench for the genomic interval variant matcher.
`timescale 1ns / 1ps

module genomic_interval_variant_matcher_tb;
  import givm_pkg::*;

  localparam int unsigned NSLOT  = MAX_INTERVALS_DEF;
  localparam int unsigned NEXON  = MAX_EXONS_DEF;
  localparam int unsigned LIMIT  = 4000000;  // cycles, far above the slowest legal run
  localparam int unsigned SETTLE = 64;       // quiet cycles before a mode write / the end

  typedef struct {
    bit              hit;
    bit [IDX_W-1:0]  idx;
    bit [VAR_W-1:0]  var_no;
    bit              last;
  } match_beat_t;

  // Interval table model plus the queue of result beats still owed by the block.
  class match_scoreboard;
    bit [MODE_W-1:0]  mode;
    int unsigned      n_int;
    bit [31:0]        n_query;
    bit [CHROM_W-1:0] chrom [NSLOT];
    bit [31:0]        tx_lo [NSLOT], tx_hi [NSLOT], cd_lo [NSLOT], cd_hi [NSLOT];
    int unsigned      n_exon [NSLOT];
    longint unsigned  ex_start [NSLOT*NEXON], ex_size [NSLOT*NEXON];
    match_beat_t      owed [$];
    int unsigned      queries, hits;

    function void clear_table();
      n_int   = 0;
      n_query = 0;
    endfunction

    function bit slot_hits(int unsigned s, bit [CHROM_W-1:0] c, longint unsigned pos,
                           bit [MODE_W-1:0] m);
      longint unsigned lo, hi;
      bit in_ex;
      if (chrom[s] != c) return 0;
      if (m == MODE_CODING) begin
        lo = cd_lo[s];
        hi = cd_hi[s];
        if (hi <= lo) return 0;
      end else begin
        lo = tx_lo[s];
        hi = tx_hi[s];
      end
      if (pos < lo || pos > hi) return 0;
      if (m == MODE_TX) return 1;
      in_ex = 0;
      for (int e = 0; e < n_exon[s]; e++)
        if (pos >= ex_start[s*NEXON+e] && pos <= ex_start[s*NEXON+e] + ex_size[s*NEXON+e])
          in_ex = 1;
      return in_ex;
    endfunction

    // One accepted input beat: update the table, queue any result beats.
    function void note_input(bit [CMD_W-1:0] cmd, bit [CHROM_W-1:0] c, bit [POS_W-1:0] a,
                             bit [POS_W-1:0] b, bit [POS_W-1:0] cs, bit [POS_W-1:0] ce);
      bit [MODE_W-1:0] m;
      match_beat_t     bt;
      int unsigned     k, n;
      m = (mode == 2'd3) ? MODE_TX : mode;
      case (cmd)
        CMD_CLEAR: clear_table();
        CMD_ADD_INT: begin
          if (n_int < NSLOT) begin
            chrom[n_int]  = c;
            tx_lo[n_int]  = a + 32'd1;
            tx_hi[n_int]  = b + 32'd1;
            cd_lo[n_int]  = cs + 32'd1;
            cd_hi[n_int]  = ce + 32'd1;
            n_exon[n_int] = 0;
            n_int++;
          end
        end
        CMD_ADD_EXON: begin
          if (n_int > 0 && n_exon[n_int-1] < NEXON) begin
            k = n_int - 1;
            ex_start[k*NEXON+n_exon[k]] = longint'(tx_lo[k]) + a;
            ex_size[k*NEXON+n_exon[k]]  = b;
            n_exon[k]++;
          end
        end
        default: begin
          queries++;
          n = 0;
          for (int s = 0; s < n_int; s++) begin
            if (slot_hits(s, c, a, m)) begin
              bt.hit = 1; bt.idx = IDX_W'(s); bt.var_no = n_query; bt.last = 0;
              owed.insert(owed.size(), bt);
              n++;
            end
          end
          hits += n;
          if (n == 0) begin
            bt.hit = 0; bt.idx = 0; bt.var_no = n_query; bt.last = 1;
            owed.insert(owed.size(), bt);
          end else begin
            owed[owed.size()-1].last = 1;
          end
          n_query++;
        end
      endcase
    endfunction

    // Compare one accepted result beat against the oldest owed beat.
    function bit check_result(bit h, bit [IDX_W-1:0] i, bit [VAR_W-1:0] v, bit l,
                              output string why);
      match_beat_t e;
      if (owed.size() == 0) begin
        why = $sformatf("unexpected beat hit=%0d idx=%0d var=%0d last=%0d", h, i, v, l);
        return 0;
      end
      e = owed.pop_front();
      if (e.hit != h || e.idx != i || e.var_no != v || e.last != l) begin
        why = $sformatf("beat got hit=%0d idx=%0d var=%0d last=%0d, want %0d/%0d/%0d/%0d",
                        h, i, v, l, e.hit, e.idx, e.var_no, e.last);
        return 0;
      end
      why = "";
      return 1;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [MODE_W-1:0]   cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    cmd_i = CMD_CLEAR;
  logic [CHROM_W-1:0]  chrom_id_i = '0;
  logic [POS_W-1:0]    pos_a_i = '0, pos_b_i = '0, coding_start_i = '0, coding_end_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                hit_o;
  logic [IDX_W-1:0]    interval_index_o;
  logic [VAR_W-1:0]    variant_index_o;
  logic                last_o;

  genomic_interval_variant_matcher dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .cmd_i, .chrom_id_i, .pos_a_i, .pos_b_i,
    .coding_start_i, .coding_end_i, .out_valid_o, .out_stall_i,
    .hit_o, .interval_index_o, .variant_index_o, .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  match_scoreboard sb = new();
  int unsigned errors    = 0;
  int unsigned cycles    = 0;
  int unsigned send_pct  = 0;   // sender idle chance per cycle, percent
  int unsigned recv_pct  = 0;   // receiver stall chance per cycle, percent
  int unsigned hold_left = 0;   // long receiver hold-off, in cycles
  int unsigned beats_out = 0;
  int unsigned modes_seen = 0;

  task automatic report(input string why);
    $display("MISMATCH @%0d: %s", cycles, why);
    errors++;
  endtask

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycles, sb.owed.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: sample pre-edge values, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    string why;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (!sb.check_result(hit_o, interval_index_o, variant_index_o, last_o, why))
        report(why);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_pct);
    end
  end

  // Offer one command beat; leaves valid high so back-to-back beats need no dip.
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CHROM_W-1:0] c,
                           input logic [POS_W-1:0] a, input logic [POS_W-1:0] b,
                           input logic [POS_W-1:0] cs, input logic [POS_W-1:0] ce);
    if ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_pct) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    chrom_id_i     <= c;
    pos_a_i        <= a;
    pos_b_i        <= b;
    coding_start_i <= cs;
    coding_end_i   <= ce;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(cmd, c, a, b, cs, ce);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    go_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.mode = m;
    modes_seen |= 1 << m;
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(32'h7FFF_FFFE));
  endfunction

  // Interval with a handful of ordered exons, on one of a few chromosomes.
  task automatic add_gene(input int unsigned n_ex);
    logic [CHROM_W-1:0] c;
    logic [POS_W-1:0]   st, len, off, cs, ce;
    c   = $urandom_range(3);
    st  = ($urandom_range(9) == 0) ? $urandom_range(32'h7FF0_0000) : $urandom_range(4000);
    len = $urandom_range(2000, 20);
    cs  = st + $urandom_range(len / 2);
    ce  = ($urandom_range(5) == 0) ? cs - $urandom_range(1) : cs + $urandom_range(len / 2);
    send_beat(CMD_ADD_INT, c, st, st + len, cs, ce);
    off = 0;
    for (int e = 0; e < n_ex; e++) begin
      off += $urandom_range(len / (n_ex + 1));
      send_beat(CMD_ADD_EXON, rand_pos(), off, $urandom_range(len / (n_ex + 2)),
                rand_pos(), rand_pos());
    end
  endtask

  // Query aimed near a stored interval, or anywhere.
  task automatic send_query();
    int unsigned        s;
    logic [CHROM_W-1:0] c;
    logic [POS_W-1:0]   p;
    if (sb.n_int > 0 && $urandom_range(7) != 0) begin
      s = $urandom_range(sb.n_int - 1);
      c = ($urandom_range(5) == 0) ? $urandom_range(3) : sb.chrom[s];
      p = sb.tx_lo[s] + $urandom_range(sb.tx_hi[s] - sb.tx_lo[s] + 4) - 2;
    end else begin
      c = $urandom_range(255);
      p = rand_pos();
    end
    send_beat(CMD_QUERY, c, p, rand_pos(), rand_pos(), rand_pos());
  endtask

  task automatic random_batch(input int unsigned n);
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 3) send_beat(CMD_CLEAR, rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos());
      else if (r < 10)
        send_beat($urandom_range(3), $urandom_range(255), rand_pos(), rand_pos(),
                  rand_pos(), rand_pos());
      else if (r < 35) add_gene(($urandom_range(15) == 0) ? 18 : $urandom_range(4));
      else send_query();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: exon on an empty table, query on an empty table, field extremes,
    // empty coding range, every mode, then clear.
    send_beat(CMD_ADD_EXON, 8'd0, 31'd5, 31'd5, '0, '0);
    send_beat(CMD_QUERY, 8'd0, 31'd0, '0, '0, '0);
    send_beat(CMD_ADD_INT, 8'hFF, 31'd0, 31'h7FFF_FFFD, 31'd0, 31'h7FFF_FFFD);
    send_beat(CMD_ADD_EXON, 8'hFF, 31'd0, 31'd0, '0, '0);
    send_beat(CMD_ADD_EXON, 8'hFF, 31'h7FFF_FFFC, 31'h7FFF_FFFE, 31'h7FFF_FFFE, '1);
    send_beat(CMD_ADD_INT, 8'hFF, 31'd100, 31'd200, 31'd150, 31'd150);
    send_beat(CMD_ADD_EXON, 8'h00, 31'd10, 31'd50, '0, '0);
    send_beat(CMD_QUERY, 8'hFF, 31'h7FFF_FFFE, '1, '1, '1);
    send_beat(CMD_QUERY, 8'hFF, 31'd0, '0, '0, '0);
    send_beat(CMD_QUERY, 8'hFF, 31'd1, '0, '0, '0);
    send_beat(CMD_QUERY, 8'hFF, 31'd151, '0, '0, '0);
    send_beat(CMD_QUERY, 8'hFE, 31'd151, '0, '0, '0);
    for (int m = 1; m < 4; m++) begin
      write_mode(MODE_W'(m));
      send_beat(CMD_QUERY, 8'hFF, 31'd1, '0, '0, '0);
      send_beat(CMD_QUERY, 8'hFF, 31'd151, '0, '0, '0);
      send_beat(CMD_QUERY, 8'hFF, 31'h7FFF_FFFE, '0, '0, '0);
    end
    send_beat(CMD_CLEAR, '1, '1, '1, '1, '1);
    send_beat(CMD_QUERY, 8'hFF, 31'd151, '0, '0, '0);

    // Random phases over every mode and idling profile.
    for (int ph = 0; ph < 8; ph++) begin
      write_mode(MODE_W'(ph % 4));
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 50; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 50; end
        default: begin send_pct = 28; recv_pct = 28; end
      endcase
      random_batch(10);
    end

    // Full table: load past capacity, tack exons past the per-interval limit.
    write_mode(MODE_EXON);
    send_pct = 0; recv_pct = 0;
    send_beat(CMD_CLEAR, '0, '0, '0, '0, '0);
    for (int k = 0; k < NSLOT + 2; k++)
      add_gene(k == NSLOT - 1 ? NEXON + 2 : ((k % 8 == 0) ? 1 : 0));
    random_batch(10);
    write_mode(MODE_TX);

    // Back-pressure: long receiver hold-off while queries keep coming.
    hold_left = 3000;
    for (int k = 0; k < 20; k++) send_query();
    random_batch(10);

    write_mode(MODE_CODING);
    random_batch(10);

    go_idle();
    $display("Covered %0d queries, %0d hit beats, %0d result beats, mode mask %0h",
             sb.queries, sb.hits, beats_out, modes_seen);
    $display("Mismatches: %0d, cycles: %0d", errors, cycles);
    if (errors == 0 && sb.owed.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
